// ----- design/accalu_pkg.sv -----
`default_nettype none

package accalu_pkg;

   // operation codes carried in the kind field
   localparam logic [4:0] KIND_ADD       = 5'd0;
   localparam logic [4:0] KIND_ADC       = 5'd1;
   localparam logic [4:0] KIND_SUB       = 5'd2;
   localparam logic [4:0] KIND_SBB       = 5'd3;
   localparam logic [4:0] KIND_AND       = 5'd4;
   localparam logic [4:0] KIND_XOR       = 5'd5;
   localparam logic [4:0] KIND_OR        = 5'd6;
   localparam logic [4:0] KIND_CMP       = 5'd7;
   localparam logic [4:0] KIND_INC       = 5'd8;
   localparam logic [4:0] KIND_DEC       = 5'd9;
   localparam logic [4:0] KIND_RLC       = 5'd10;
   localparam logic [4:0] KIND_RRC       = 5'd11;
   localparam logic [4:0] KIND_RAL       = 5'd12;
   localparam logic [4:0] KIND_RAR       = 5'd13;
   localparam logic [4:0] KIND_CMA       = 5'd14;
   localparam logic [4:0] KIND_CMC       = 5'd15;
   localparam logic [4:0] KIND_STC       = 5'd16;
   localparam logic [4:0] KIND_DAD       = 5'd17;
   localparam logic [4:0] KIND_LOADA     = 5'd18;
   localparam logic [4:0] KIND_LOADFLAGS = 5'd19;

   // bit positions in a status byte
   localparam int unsigned PSW_SIGN   = 7;
   localparam int unsigned PSW_ZERO   = 6;
   localparam int unsigned PSW_PARITY = 2;
   localparam int unsigned PSW_CARRY  = 0;

   typedef struct packed {
      logic [4:0]  kind;
      logic [7:0]  operand;
      logic [15:0] pair_value;
      logic [15:0] hl_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  byte_result;
      logic [15:0] wide_result;
      logic        zero;
      logic        sign;
      logic        parity;
      logic        carry;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/accumulator_alu_with_flags_core.sv -----
`default_nettype none

// Accumulator ALU with zero, sign, parity and carry flags in the style of a
// classic 8-bit microprocessor. A request is captured in an input register,
// evaluated by one pass of byte and 16-bit adders and logic against the held
// accumulator and flags, and the result lands in an output register.
// One request is taken every cycle unless the output register is stalled;
// the loop from the accumulator and flag registers through the ALU back to
// themselves sets the clock. The response shows the accumulator and flags
// after the operation.
module accumulator_alu_with_flags_core (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  accalu_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output accalu_pkg::rsp_type  rsp_data
);
   import accalu_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   logic    advance;

   logic [7:0] acc_ff, acc_in;
   logic       zero_ff, zero_in;
   logic       sign_ff, sign_in;
   logic       parity_ff, parity_in;
   logic       carry_ff, carry_in;

   logic [7:0]  byte_res;
   logic [15:0] wide_res;
   logic [8:0]  sum9;
   logic [8:0]  sub_rhs;
   logic [8:0]  diff9;
   logic [16:0] sum17;
   logic        cin;

   // advance when the output register is free or being drained
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   // capture request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // shared adders
   always_comb begin
      cin     = ((in_ff.kind == KIND_ADC) || (in_ff.kind == KIND_SBB)) ? carry_ff : 1'b0;
      sum9    = {1'b0, acc_ff} + {1'b0, in_ff.operand} + {8'd0, cin};
      sub_rhs = {1'b0, in_ff.operand} + {8'd0, cin};
      diff9   = {1'b0, acc_ff} - sub_rhs;
      sum17   = {1'b0, in_ff.hl_value} + {1'b0, in_ff.pair_value};
   end

   // operation decode and next state
   always_comb begin
      acc_in    = acc_ff;
      zero_in   = zero_ff;
      sign_in   = sign_ff;
      parity_in = parity_ff;
      carry_in  = carry_ff;
      byte_res  = acc_ff;
      wide_res  = '0;
      unique case (in_ff.kind)
         KIND_ADD, KIND_ADC: begin
            byte_res = sum9[7:0];
            carry_in = sum9[8];
            acc_in   = byte_res;
         end
         KIND_SUB, KIND_SBB: begin
            byte_res = diff9[7:0];
            carry_in = diff9[8];
            acc_in   = byte_res;
         end
         KIND_CMP: begin
            byte_res = diff9[7:0];
            carry_in = diff9[8];
         end
         KIND_AND: begin
            byte_res = acc_ff & in_ff.operand;
            carry_in = 1'b0;
            acc_in   = byte_res;
         end
         KIND_XOR: begin
            byte_res = acc_ff ^ in_ff.operand;
            carry_in = 1'b0;
            acc_in   = byte_res;
         end
         KIND_OR: begin
            byte_res = acc_ff | in_ff.operand;
            carry_in = 1'b0;
            acc_in   = byte_res;
         end
         KIND_INC: begin
            byte_res = in_ff.operand + 8'd1;
         end
         KIND_DEC: begin
            byte_res = in_ff.operand - 8'd1;
         end
         KIND_RLC: begin
            byte_res = {acc_ff[6:0], acc_ff[7]};
            carry_in = acc_ff[7];
            acc_in   = byte_res;
         end
         KIND_RRC: begin
            byte_res = {acc_ff[0], acc_ff[7:1]};
            carry_in = acc_ff[0];
            acc_in   = byte_res;
         end
         KIND_RAL: begin
            byte_res = {acc_ff[6:0], carry_ff};
            carry_in = acc_ff[7];
            acc_in   = byte_res;
         end
         KIND_RAR: begin
            byte_res = {carry_ff, acc_ff[7:1]};
            carry_in = acc_ff[0];
            acc_in   = byte_res;
         end
         KIND_CMA: begin
            byte_res = ~acc_ff;
            acc_in   = byte_res;
         end
         KIND_CMC: begin
            carry_in = ~carry_ff;
         end
         KIND_STC: begin
            carry_in = 1'b1;
         end
         KIND_DAD: begin
            wide_res = sum17[15:0];
            carry_in = sum17[16];
         end
         KIND_LOADA: begin
            byte_res = in_ff.operand;
            acc_in   = in_ff.operand;
         end
         KIND_LOADFLAGS: begin
            byte_res  = in_ff.operand;
            sign_in   = in_ff.operand[PSW_SIGN];
            zero_in   = in_ff.operand[PSW_ZERO];
            parity_in = in_ff.operand[PSW_PARITY];
            carry_in  = in_ff.operand[PSW_CARRY];
         end
         default: begin
         end
      endcase
      // arithmetic, logic and compare operations, inc and dec set zero, sign and parity from the result
      if ((in_ff.kind <= KIND_CMP) || (in_ff.kind == KIND_INC) ||
          (in_ff.kind == KIND_DEC)) begin
         zero_in   = (byte_res == 8'd0);
         sign_in   = byte_res[7];
         parity_in = ~^byte_res;
      end
   end

   // update state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         zero_ff      <= 1'b0;
         sign_ff      <= 1'b0;
         parity_ff    <= 1'b0;
         carry_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            acc_ff    <= acc_in;
            zero_ff   <= zero_in;
            sign_ff   <= sign_in;
            parity_ff <= parity_in;
            carry_ff  <= carry_in;
         end
      end
      if (advance) begin
         rsp_ff.acc         <= acc_in;
         rsp_ff.byte_result <= byte_res;
         rsp_ff.wide_result <= wide_res;
         rsp_ff.zero        <= zero_in;
         rsp_ff.sign        <= sign_in;
         rsp_ff.parity      <= parity_in;
         rsp_ff.carry       <= carry_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_cmp_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      advance && (in_ff.kind == KIND_CMP) |=> acc_ff == $past(acc_ff))
      else $error("compare changed the accumulator");

   a_incdec_keeps_carry: assert property (@(posedge clock) disable iff (reset)
      advance && ((in_ff.kind == KIND_INC) || (in_ff.kind == KIND_DEC))
      |=> carry_ff == $past(carry_ff))
      else $error("increment or decrement changed carry");

   a_logic_clears_carry: assert property (@(posedge clock) disable iff (reset)
      advance && ((in_ff.kind == KIND_AND) || (in_ff.kind == KIND_XOR) ||
                  (in_ff.kind == KIND_OR)) |=> !carry_ff)
      else $error("logic operation left carry set");

   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && (rsp_ff.acc == acc_ff) && (rsp_ff.carry == carry_ff))
      else $error("response does not match updated state");
`endif

endmodule

`default_nettype wire

// ----- verif/accumulator_alu_with_flags_core_tb.sv -----
`timescale 1ns / 1ps

module accumulator_alu_with_flags_core_tb;
   import accalu_pkg::*;

   // kinds past the last defined operation leave all state alone
   localparam logic [4:0] KIND_SPARE_FIRST = 5'd20;
   localparam logic [4:0] KIND_SPARE_LAST  = 5'd31;

   localparam int RANDOM_ITEMS     = 700;
   localparam int PAUSE_AT_ITEM    = 450;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES     = 20;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // architectural state as the predictor sees it
   logic [7:0] acc_now = 8'h00;
   logic       flag_z  = 1'b0;
   logic       flag_s  = 1'b0;
   logic       flag_p  = 1'b0;
   logic       flag_c  = 1'b0;

   rsp_type     awaited_results[$];
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;

   // directed requests, walked in order from reset; typed rows carry their result
   stim_row_type directed_rows [25] = '{
      '{'{KIND_ADD,   8'h00, 16'h1234, 16'h4321}, 1'b1,
        '{8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{KIND_LOADA, 8'hFF, 16'h0000, 16'h0000}, 1'b1,
        '{8'hFF, 8'hFF, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{KIND_ADD,   8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{8'hFE, 8'hFE, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b1}},
      '{'{KIND_ADC,   8'h01, 16'h0000, 16'h0000}, 1'b1,
        '{8'h00, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{'{KIND_SUB,   8'h01, 16'h0000, 16'h0000}, 1'b1,
        '{8'hFF, 8'hFF, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b1}},
      '{'{KIND_SBB,   8'hFF, 16'h0000, 16'h0000}, 1'b1,
        '{8'hFF, 8'hFF, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b1}},
      '{'{KIND_CMP,   8'hFF, 16'h0000, 16'h0000}, 1'b1,
        '{8'hFF, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{KIND_AND,   8'h0F, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_XOR,   8'hFF, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_OR,    8'h80, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_INC,   8'hFF, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_DEC,   8'h00, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_RLC,   8'h00, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_RRC,   8'h00, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_RAL,   8'h00, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_RAR,   8'h00, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_CMA,   8'h55, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_CMC,   8'hAA, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_STC,   8'h00, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_DAD,   8'h00, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{KIND_DAD,   8'hFF, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_LOADFLAGS, 8'hFF, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_LOADFLAGS, 8'h3A, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{KIND_SPARE_FIRST, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{KIND_SPARE_LAST,  8'h00, 16'h0000, 16'h0000}, 1'b0, '0}
   };

   accumulator_alu_with_flags_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // zero, sign and even parity from a byte result
   function automatic void note_zsp(input logic [7:0] v);
      flag_z = (v == 8'h00);
      flag_s = v[7];
      flag_p = ~^v;
   endfunction

   // apply one request to the held state and return the response it yields
   function automatic rsp_type alu_result_of(input req_type rq);
      rsp_type     res;
      logic [7:0]  old_a;
      logic [8:0]  sum9;
      logic [8:0]  take9;
      logic [16:0] sum17;
      old_a = acc_now;
      res = '0;
      res.byte_result = old_a;
      case (rq.kind)
         KIND_ADD, KIND_ADC: begin
            sum9 = {1'b0, old_a} + {1'b0, rq.operand}
                   + {8'b0, (rq.kind == KIND_ADC) & flag_c};
            res.byte_result = sum9[7:0];
            note_zsp(sum9[7:0]);
            flag_c = sum9[8];
            acc_now = sum9[7:0];
         end
         KIND_SUB, KIND_SBB, KIND_CMP: begin
            take9 = {1'b0, rq.operand} + {8'b0, (rq.kind == KIND_SBB) & flag_c};
            sum9 = {1'b0, old_a} - take9;
            res.byte_result = sum9[7:0];
            note_zsp(sum9[7:0]);
            flag_c = ({1'b0, old_a} < take9);
            if (rq.kind != KIND_CMP) begin
               acc_now = sum9[7:0];
            end
         end
         KIND_AND, KIND_XOR, KIND_OR: begin
            if (rq.kind == KIND_AND) begin
               res.byte_result = old_a & rq.operand;
            end else if (rq.kind == KIND_XOR) begin
               res.byte_result = old_a ^ rq.operand;
            end else begin
               res.byte_result = old_a | rq.operand;
            end
            note_zsp(res.byte_result);
            flag_c = 1'b0;
            acc_now = res.byte_result;
         end
         KIND_INC: begin
            res.byte_result = rq.operand + 8'd1;
            note_zsp(res.byte_result);
         end
         KIND_DEC: begin
            res.byte_result = rq.operand - 8'd1;
            note_zsp(res.byte_result);
         end
         KIND_RLC: begin
            flag_c = old_a[7];
            res.byte_result = {old_a[6:0], old_a[7]};
            acc_now = res.byte_result;
         end
         KIND_RRC: begin
            flag_c = old_a[0];
            res.byte_result = {old_a[0], old_a[7:1]};
            acc_now = res.byte_result;
         end
         KIND_RAL: begin
            res.byte_result = {old_a[6:0], flag_c};
            flag_c = old_a[7];
            acc_now = res.byte_result;
         end
         KIND_RAR: begin
            res.byte_result = {flag_c, old_a[7:1]};
            flag_c = old_a[0];
            acc_now = res.byte_result;
         end
         KIND_CMA: begin
            res.byte_result = ~old_a;
            acc_now = res.byte_result;
         end
         KIND_CMC: begin
            flag_c = ~flag_c;
         end
         KIND_STC: begin
            flag_c = 1'b1;
         end
         KIND_DAD: begin
            sum17 = {1'b0, rq.hl_value} + {1'b0, rq.pair_value};
            res.wide_result = sum17[15:0];
            flag_c = sum17[16];
         end
         KIND_LOADA: begin
            acc_now = rq.operand;
            res.byte_result = rq.operand;
         end
         KIND_LOADFLAGS: begin
            flag_s = rq.operand[PSW_SIGN];
            flag_z = rq.operand[PSW_ZERO];
            flag_p = rq.operand[PSW_PARITY];
            flag_c = rq.operand[PSW_CARRY];
            res.byte_result = rq.operand;
         end
         default: begin
         end
      endcase
      res.acc    = acc_now;
      res.zero   = flag_z;
      res.sign   = flag_s;
      res.parity = flag_p;
      res.carry  = flag_c;
      return res;
   endfunction

   // random request, leaning toward the byte and word extremes
   function automatic req_type random_request();
      req_type    rq;
      logic [7:0]  byte_edges [5];
      logic [15:0] word_edges [4];
      byte_edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
      word_edges = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
      if ($urandom_range(0, 15) == 0) begin
         rq.kind = 5'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      end else begin
         rq.kind = 5'($urandom_range(KIND_ADD, KIND_LOADFLAGS));
      end
      rq.operand = ($urandom_range(0, 3) == 0) ? byte_edges[$urandom_range(0, 4)]
                                                : 8'($urandom);
      rq.pair_value = ($urandom_range(0, 3) == 0) ? word_edges[$urandom_range(0, 3)]
                                                   : 16'($urandom);
      rq.hl_value = ($urandom_range(0, 3) == 0) ? word_edges[$urandom_range(0, 3)]
                                                 : 16'($urandom);
      return rq;
   endfunction

   // offer one request after an idle gap, hold it until taken, then log its result
   task automatic send_request(input req_type rq, input int gap, input bit typed,
                               input rsp_type typed_rsp);
      rsp_type modeled;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!(req_valid && req_ready));
      modeled = alu_result_of(rq);
      awaited_results.push_back(typed ? typed_rsp : modeled);
   endtask

   task automatic compare_field(input string name, input logic [15:0] want_v,
                                input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // request side: directed table, then random traffic with bursts and one full drain
   initial begin : request_side
      int gap;
      bit burst;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      burst = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, $urandom_range(0, 11),
                      directed_rows[i].typed, directed_rows[i].want);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            burst = ($urandom_range(0, 3) == 0);
         end
         // hold off until every outstanding result has come back
         if (n == PAUSE_AT_ITEM) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (awaited_results.size() != 0);
         end
         gap = burst ? 0 : $urandom_range(0, 11);
         send_request(random_request(), gap, 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS accumulator_alu_with_flags_core");
      end else begin
         $display("FAIL accumulator_alu_with_flags_core");
      end
      $finish;
   end

   // response side: random stalls, steady stretches and one long hold-off
   initial begin : response_side
      int hold;
      int taken;
      bit steady;
      rsp_ready = 1'b0;
      taken = 0;
      steady = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 40 == 0) begin
            steady = ($urandom_range(0, 2) == 0);
         end
         if (taken == LONG_HOLD_AT) begin
            hold = LONG_HOLD_CYCLES;
         end else begin
            hold = steady ? 0 : $urandom_range(0, 11);
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   // check each accepted response against the oldest outstanding result
   always @(posedge clock) begin : check_response
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: response with none outstanding, expected nothing, actual %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            compare_field("acc", 16'(want.acc), 16'(rsp_data.acc));
            compare_field("byte_result", 16'(want.byte_result), 16'(rsp_data.byte_result));
            compare_field("wide_result", want.wide_result, rsp_data.wide_result);
            compare_field("zero", 16'(want.zero), 16'(rsp_data.zero));
            compare_field("sign", 16'(want.sign), 16'(rsp_data.sign));
            compare_field("parity", 16'(want.parity), 16'(rsp_data.parity));
            compare_field("carry", 16'(want.carry), 16'(rsp_data.carry));
         end
      end
   end

   // end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL accumulator_alu_with_flags_core");
         $finish;
      end
   end

endmodule
